// File: sv/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg
// shared constants, command codes, register indexes and the cordic table
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_SET_POSE = 1'b1;

  localparam logic [1:0] REG_LEFT_GAIN = 2'd0;
  localparam logic [1:0] REG_RIGHT_GAIN = 2'd1;
  localparam logic [1:0] REG_WHEEL_BASE = 2'd2;

  localparam logic [17:0] GAIN_RESET = 18'd65536;
  localparam logic [23:0] BASE_RESET = 24'd32768;

  localparam logic signed [39:0] TWO_PI_Q30 = 40'sd6746518852;
  localparam logic signed [39:0] PI_Q30 = 40'sd3373259426;
  localparam logic signed [39:0] HALF_PI_Q30 = 40'sd1686629713;
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 30'h3243F6A8;
      5'd1: atan_q30 = 30'h1DAC6705;
      5'd2: atan_q30 = 30'h0FADBAFC;
      5'd3: atan_q30 = 30'h07F56EA6;
      5'd4: atan_q30 = 30'h03FEAB76;
      5'd5: atan_q30 = 30'h01FFD55B;
      5'd6: atan_q30 = 30'h00FFFAAA;
      5'd7: atan_q30 = 30'h007FFF55;
      5'd8: atan_q30 = 30'h003FFFEA;
      5'd9: atan_q30 = 30'h001FFFFD;
      5'd10: atan_q30 = 30'h000FFFFF;
      5'd11: atan_q30 = 30'h0007FFFF;
      5'd12: atan_q30 = 30'h0003FFFF;
      5'd13: atan_q30 = 30'h0001FFFF;
      5'd14: atan_q30 = 30'h0000FFFF;
      5'd15: atan_q30 = 30'h00007FFF;
      5'd16: atan_q30 = 30'h00003FFF;
      5'd17: atan_q30 = 30'h00001FFF;
      5'd18: atan_q30 = 30'h00000FFF;
      5'd19: atan_q30 = 30'h000007FF;
      5'd20: atan_q30 = 30'h000003FF;
      5'd21: atan_q30 = 30'h000001FF;
      5'd22: atan_q30 = 30'h000000FF;
      5'd23: atan_q30 = 30'h0000007F;
      5'd24: atan_q30 = 30'h0000003F;
      5'd25: atan_q30 = 30'h0000001F;
      5'd26: atan_q30 = 30'h0000000F;
      5'd27: atan_q30 = 30'h00000008;
      5'd28: atan_q30 = 30'h00000004;
      5'd29: atan_q30 = 30'h00000002;
      5'd30: atan_q30 = 30'h00000001;
      default: atan_q30 = 30'h00000000;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: sv/ddo_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_if
// valid/ready channels: input items, result items and register writes
// ----------------------------------------------------------------------------
interface ddo_in_if;
  logic valid;
  logic ready;
  logic command;
  logic signed [31:0] left_speed;
  logic signed [31:0] right_speed;
  logic [23:0] step_time;
  logic signed [31:0] set_x;
  logic signed [31:0] set_y;
  logic signed [31:0] set_heading;
  modport source (output valid, command, left_speed, right_speed, step_time,
                  set_x, set_y, set_heading, input ready);
  modport sink (input valid, command, left_speed, right_speed, step_time,
                set_x, set_y, set_heading, output ready);
endinterface

interface ddo_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] linear_speed;
  logic signed [31:0] turn_rate;
  logic saturated;
  modport source (output valid, pos_x, pos_y, heading, linear_speed, turn_rate,
                  saturated, input ready);
  modport sink (input valid, pos_x, pos_y, heading, linear_speed, turn_rate,
                saturated, output ready);
endinterface

interface ddo_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/ddo_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_mul
// bit-serial signed multiplier: one multiplier bit per cycle, exact product
// ----------------------------------------------------------------------------
module ddo_mul
  import ddo_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [39:0] a,
  input  wire logic signed [39:0] b,
  output logic                    done,
  output logic signed [79:0]      prod
);
  logic [5:0] cnt;
  logic busy;
  logic signed [40:0] acc;
  logic [39:0] mb;
  logic signed [39:0] ma;
  logic signed [40:0] addend;
  logic signed [40:0] sum;

  always_comb begin
    addend = mb[0] ? {ma[39], ma} : 41'sd0;
    if (cnt == 6'd39 && mb[0]) addend = -{ma[39], ma};
    sum = acc + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        acc <= '0;
        ma <= a;
        mb <= b;
      end else if (busy) begin
        acc <= sum >>> 1;
        mb <= {sum[0], mb[39:1]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd39) begin
          busy <= 1'b0;
          done <= 1'b1;
          prod <= {sum[40:0], mb[39:1]};
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/ddo_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_div
// restoring divider, one quotient bit per cycle, truncating toward zero
// ----------------------------------------------------------------------------
module ddo_div
  import ddo_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [49:0] num,
  input  wire logic [23:0]        den,
  output logic                    done,
  output logic signed [49:0]      quot
);
  logic busy;
  logic neg;
  logic [5:0] cnt;
  logic [49:0] q;
  logic [23:0] rem;
  logic [23:0] d;
  logic [24:0] trial;
  logic [24:0] diff;

  always_comb begin
    trial = {rem, q[49]};
    diff = trial - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= num[49];
        q <= num[49] ? -num : num;
        rem <= '0;
        d <= den;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (!diff[24]) begin
          rem <= diff[23:0];
          q <= {q[48:0], 1'b1};
        end else begin
          rem <= trial[23:0];
          q <= {q[48:0], 1'b0};
        end
        if (cnt == 6'd49) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(q) : $signed(q);
endmodule
`default_nettype wire

// File: sv/ddo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cordic
// rotation-mode cordic, one micro-rotation per cycle, q2.30 sin and cos
// ----------------------------------------------------------------------------
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int ITER = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [39:0] angle,
  output logic                    done,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o
);
  logic busy;
  logic flip;
  logic [4:0] i;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [39:0] r;
  logic signed [39:0] at;

  assign at = $signed({10'd0, atan_q30(i)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i <= '0;
        x <= CORDIC_K_Q30;
        y <= '0;
        if (angle > HALF_PI_Q30) begin
          r <= angle - PI_Q30;
          flip <= 1'b1;
        end else if (angle < -HALF_PI_Q30) begin
          r <= angle + PI_Q30;
          flip <= 1'b1;
        end else begin
          r <= angle;
          flip <= 1'b0;
        end
      end else if (busy) begin
        if (!r[39]) begin
          x <= x - (y >>> i);
          y <= y + (x >>> i);
          r <= r - at;
        end else begin
          x <= x + (y >>> i);
          y <= y - (x >>> i);
          r <= r + at;
        end
        i <= i + 5'd1;
        if (32'(i) == ITER - 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_o = flip ? -x : x;
  assign sin_o = flip ? -y : y;
endmodule
`default_nettype wire

// File: sv/diff_drive_odometry_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_odometry_core
// two-wheel dead reckoning with midpoint heading, fixed point
//
// channels: item input (step or set pose), result output, register writes.
// every accepted item gives one result beat with pose, speeds, saturation.
// a set-pose item has its result valid in the cycle after accept. a step
// item runs on one shared bit-serial multiplier (six products, each with
// issue and collect), a serial divider for the turn rate (50 iterations),
// an angle reduction by repeated add/subtract of 2pi and the cordic with
// TRIG_ITERATIONS micro-rotations (at most 32), one item at a time.
// the result sits in an output register until taken; a stalled receiver
// holds the block with the result intact and no new item is taken.
// reset clears pose, speeds, gains and wheel base to their reset values.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core
  import ddo_pkg::*;
#(
  parameter int TRIG_ITERATIONS = 24
) (
  input wire logic clk,
  input wire logic rst,
  ddo_in_if.sink   in_ch,
  ddo_out_if.source out_ch,
  ddo_cfg_if.sink  cfg
);
  localparam int ITER = (TRIG_ITERATIONS < 32) ? TRIG_ITERATIONS : 32;

  typedef enum logic [4:0] {
    S_IDLE, S_ML, S_WL, S_MR, S_WR, S_DIV, S_WDIV, S_MD, S_WD, S_MT, S_WT,
    S_RED, S_COR, S_WCOR, S_MX, S_WX, S_MY, S_WY, S_UPD, S_OUT
  } state_t;

  state_t state;
  logic [17:0] left_gain;
  logic [17:0] right_gain;
  logic [23:0] wheel_base;
  logic signed [31:0] x_reg, y_reg, heading_reg, speed_reg, rate_reg;
  logic signed [31:0] ls, rs, w, v, travel, dth;
  logic signed [31:0] lsp, rsp;
  logic [23:0] dt;
  logic sat;
  logic signed [39:0] mid;
  logic signed [33:0] c, s;
  logic signed [33:0] dx_sum, dy_sum;

  logic mul_start, mul_done;
  logic signed [39:0] mul_a, mul_b;
  logic signed [79:0] prod;
  logic div_start, div_done;
  logic signed [49:0] div_num, quot;
  logic cor_start, cor_done;
  logic signed [33:0] cos_o, sin_o;

  ddo_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .prod);
  ddo_div u_div (.clk, .rst, .start(div_start), .num(div_num),
                 .den(wheel_base == 24'd0 ? 24'd1 : wheel_base),
                 .done(div_done), .quot);
  ddo_cordic #(.ITER(ITER)) u_cor (.clk, .rst, .start(cor_start), .angle(mid),
                 .done(cor_done), .cos_o, .sin_o);

  function automatic logic signed [31:0] sat32(input logic signed [79:0] val);
    if (val > 80'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (val < -80'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = val[31:0];
  endfunction

  function automatic logic ovf(input logic signed [79:0] val);
    ovf = (val > 80'sd2147483647) || (val < -80'sd2147483648);
  endfunction

  logic signed [79:0] ps16, ps20, ps12, ps30;
  logic signed [79:0] sum_x, sum_y, sum_h;
  assign ps16 = prod >>> 16;
  assign ps20 = prod >>> 20;
  assign ps12 = prod >>> 12;
  assign ps30 = prod >>> 30;
  assign sum_x = 80'(x_reg) + 80'(dx_sum);
  assign sum_y = 80'(y_reg) + 80'(dy_sum);
  assign sum_h = 80'(heading_reg) + 80'(dth);

  assign cfg.ready = (state == S_IDLE);
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.pos_x = x_reg;
  assign out_ch.pos_y = y_reg;
  assign out_ch.heading = heading_reg;
  assign out_ch.linear_speed = speed_reg;
  assign out_ch.turn_rate = rate_reg;
  assign out_ch.saturated = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      left_gain <= GAIN_RESET;
      right_gain <= GAIN_RESET;
      wheel_base <= BASE_RESET;
      x_reg <= '0; y_reg <= '0; heading_reg <= '0;
      speed_reg <= '0; rate_reg <= '0;
      sat <= 1'b0;
      mul_start <= 1'b0; div_start <= 1'b0; cor_start <= 1'b0;
    end else begin
      mul_start <= 1'b0; div_start <= 1'b0; cor_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg.valid) begin
            case (cfg.index)
              REG_LEFT_GAIN: left_gain <= cfg.data[17:0];
              REG_RIGHT_GAIN: right_gain <= cfg.data[17:0];
              REG_WHEEL_BASE: wheel_base <= cfg.data[23:0];
              default: ;
            endcase
          end
          if (in_ch.valid) begin
            sat <= 1'b0;
            lsp <= in_ch.left_speed;
            rsp <= in_ch.right_speed;
            dt <= in_ch.step_time;
            if (in_ch.command == CMD_SET_POSE) begin
              x_reg <= in_ch.set_x;
              y_reg <= in_ch.set_y;
              heading_reg <= in_ch.set_heading;
              state <= S_OUT;
            end else begin
              state <= S_ML;
            end
          end
        end
        S_ML: begin
          mul_a <= 40'(lsp); mul_b <= 40'($signed({1'b0, left_gain}));
          mul_start <= 1'b1; state <= S_WL;
        end
        S_WL: if (mul_done) begin
          ls <= sat32(ps16); if (ovf(ps16)) sat <= 1'b1; state <= S_MR;
        end
        S_MR: begin
          mul_a <= 40'(rsp); mul_b <= 40'($signed({1'b0, right_gain}));
          mul_start <= 1'b1; state <= S_WR;
        end
        S_WR: if (mul_done) begin
          rs <= sat32(ps16); if (ovf(ps16)) sat <= 1'b1; state <= S_DIV;
        end
        S_DIV: begin
          v <= 32'((33'(ls) + 33'(rs)) >>> 1);
          div_num <= (50'(rs) - 50'(ls)) <<< 16;
          div_start <= 1'b1; state <= S_WDIV;
        end
        S_WDIV: if (div_done) begin
          w <= sat32(80'(quot)); if (ovf(80'(quot))) sat <= 1'b1; state <= S_MD;
        end
        S_MD: begin
          mul_a <= 40'(v); mul_b <= 40'($signed({1'b0, dt}));
          mul_start <= 1'b1; state <= S_WD;
        end
        S_WD: if (mul_done) begin
          travel <= sat32(ps20); if (ovf(ps20)) sat <= 1'b1; state <= S_MT;
        end
        S_MT: begin
          mul_a <= 40'(w); mul_b <= 40'($signed({1'b0, dt}));
          mul_start <= 1'b1; state <= S_WT;
        end
        S_WT: if (mul_done) begin
          dth <= sat32(ps12); if (ovf(ps12)) sat <= 1'b1;
          mid <= (40'(heading_reg) + 40'(sat32(ps12) >>> 1)) <<< 6;
          state <= S_RED;
        end
        S_RED: begin
          // bring the angle into [-pi, pi], one 2pi step a cycle
          if (mid > PI_Q30) mid <= mid - TWO_PI_Q30;
          else if (mid < -PI_Q30) mid <= mid + TWO_PI_Q30;
          else begin
            cor_start <= 1'b1; state <= S_COR;
          end
        end
        S_COR: state <= S_WCOR;
        S_WCOR: if (cor_done) begin
          c <= cos_o; s <= sin_o; state <= S_MX;
        end
        S_MX: begin
          mul_a <= 40'(travel); mul_b <= 40'(c); mul_start <= 1'b1; state <= S_WX;
        end
        S_WX: if (mul_done) begin
          dx_sum <= ps30[33:0]; state <= S_MY;
        end
        S_MY: begin
          mul_a <= 40'(travel); mul_b <= 40'(s); mul_start <= 1'b1; state <= S_WY;
        end
        S_WY: if (mul_done) begin
          dy_sum <= ps30[33:0]; state <= S_UPD;
        end
        S_UPD: begin
          x_reg <= sat32(sum_x); y_reg <= sat32(sum_y);
          heading_reg <= sat32(sum_h);
          if (ovf(sum_x) || ovf(sum_y) || ovf(sum_h)) sat <= 1'b1;
          speed_reg <= v; rate_reg <= w;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // the product of travel and a unit vector, shifted down by 30, always fits 34 bits
  assert property (@(posedge clk) disable iff (rst)
    mul_done && (state == S_WX || state == S_WY) |->
      ps30 <= 80'sd8589934591 && ps30 >= -80'sd8589934592)
    else $error("rotation product overflow");
  assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !out_ch.ready |=> state == S_OUT && $stable(x_reg))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    state == S_COR |-> mid <= PI_Q30 && mid >= -PI_Q30)
    else $error("angle not reduced");
endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives step and set-pose beats into the odometry core with random gaps and
// output back-pressure, predicts every pose and speed result in fixed point
// and compares each result beat field by field in arrival order
// ----------------------------------------------------------------------------
module testbench;
  import ddo_pkg::*;

  typedef struct {
    logic cmd;
    logic signed [31:0] ls;
    logic signed [31:0] rs;
    logic [23:0] dt;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sh;
  } odo_item_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] hd;
    logic signed [31:0] spd;
    logic signed [31:0] rate;
    logic sat;
  } pose_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic signed [31:0] MAX32 = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;

  ddo_in_if in_ch ();
  ddo_out_if out_ch ();
  ddo_cfg_if cfg ();

  diff_drive_odometry_core #(.TRIG_ITERATIONS(24)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [17:0] gain_l, gain_r;
  logic [23:0] base_w;
  logic signed [31:0] pose_x, pose_y, pose_h, last_v, last_w;
  pose_t pending_poses[$];

  function automatic logic signed [63:0] asr64(input logic signed [63:0] v, input int s);
    asr64 = v >>> s;
  endfunction

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      clip32 = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      f = 1'b1;
      clip32 = -64'sd2147483648;
    end else begin
      clip32 = v;
    end
  endfunction

  task automatic midpoint_sincos(input logic signed [63:0] a,
                                 output logic signed [63:0] c,
                                 output logic signed [63:0] s);
    logic signed [63:0] r, x, y, nx, tp, pi, hp;
    bit flip;
    tp = TWO_PI_Q30;
    pi = PI_Q30;
    hp = HALF_PI_Q30;
    r = a % tp;
    x = CORDIC_K_Q30;
    y = 0;
    flip = 1'b0;
    if (r > pi) r = r - tp;
    if (r < -pi) r = r + tp;
    if (r > hp) begin
      r = r - pi;
      flip = 1'b1;
    end else if (r < -hp) begin
      r = r + pi;
      flip = 1'b1;
    end
    for (int i = 0; i < 24; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r = r - atan_q30(i[4:0]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r = r + atan_q30(i[4:0]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic advance_pose(input odo_item_t it);
    pose_t p;
    bit f;
    logic signed [63:0] l, r, v, w, travel, dth, mid, c, s, b;
    f = 1'b0;
    if (it.cmd == CMD_SET_POSE) begin
      pose_x = it.sx;
      pose_y = it.sy;
      pose_h = it.sh;
    end else begin
      l = clip32(asr64(64'(it.ls) * $signed({46'd0, gain_l}), 16), f);
      r = clip32(asr64(64'(it.rs) * $signed({46'd0, gain_r}), 16), f);
      b = (base_w == 0) ? 64'sd1 : $signed({40'd0, base_w});
      v = asr64(l + r, 1);
      w = clip32(((r - l) * 64'sd65536) / b, f);
      travel = clip32(asr64(v * $signed({40'd0, it.dt}), 20), f);
      dth = clip32(asr64(w * $signed({40'd0, it.dt}), 12), f);
      mid = (64'(pose_h) + asr64(dth, 1)) * 64;
      midpoint_sincos(mid, c, s);
      pose_x = 32'(clip32(64'(pose_x) + asr64(travel * c, 30), f));
      pose_y = 32'(clip32(64'(pose_y) + asr64(travel * s, 30), f));
      pose_h = 32'(clip32(64'(pose_h) + dth, f));
      last_v = 32'(v);
      last_w = 32'(w);
    end
    p.px = pose_x;
    p.py = pose_y;
    p.hd = pose_h;
    p.spd = last_v;
    p.rate = last_w;
    p.sat = f;
    pending_poses.push_back(p);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == REG_LEFT_GAIN) gain_l = val[17:0];
    else if (idx == REG_RIGHT_GAIN) gain_r = val[17:0];
    else if (idx == REG_WHEEL_BASE) base_w = val[23:0];
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_poses.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // valid stays high after the beat; the next item or drain_results moves it
  task automatic send_item(input odo_item_t it, input bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 7) : 0;
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= it.cmd;
    in_ch.left_speed <= it.ls;
    in_ch.right_speed <= it.rs;
    in_ch.step_time <= it.dt;
    in_ch.set_x <= it.sx;
    in_ch.set_y <= it.sy;
    in_ch.set_heading <= it.sh;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_pose(it);
    @(negedge clk);
  endtask

  function automatic odo_item_t mk(input logic c, input logic signed [31:0] l,
                                   input logic signed [31:0] r, input logic [23:0] d,
                                   input logic signed [31:0] x, input logic signed [31:0] y,
                                   input logic signed [31:0] h);
    odo_item_t it;
    it.cmd = c;
    it.ls = l;
    it.rs = r;
    it.dt = d;
    it.sx = x;
    it.sy = y;
    it.sh = h;
    return it;
  endfunction

  function automatic logic signed [31:0] rnd_speed();
    case ($urandom_range(0, 5))
      0: rnd_speed = $urandom;
      1: rnd_speed = $signed($urandom_range(0, 20'hFFFFF)) - 32'sd524288;
      2: rnd_speed = MAX32;
      3: rnd_speed = MIN32;
      default: rnd_speed = $signed($urandom_range(0, 32'h3FFFF)) - 32'sd131072;
    endcase
  endfunction

  function automatic odo_item_t rnd_item();
    odo_item_t it;
    it.cmd = ($urandom_range(0, 9) == 0) ? CMD_SET_POSE : CMD_STEP;
    it.ls = rnd_speed();
    it.rs = ($urandom_range(0, 3) == 0) ? it.ls : rnd_speed();
    it.dt = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 20000));
    it.sx = $urandom;
    it.sy = $urandom;
    it.sh = ($urandom_range(0, 1) == 0) ? 32'($urandom)
            : $signed($urandom_range(0, 32'h0FFFFFFF)) - 32'sh08000000;
    return it;
  endfunction

  // directed rows: expectation typed in only where obvious
  typedef struct {
    odo_item_t it;
    bit known;
    pose_t want;
  } row_t;

  // result checking and receiver stalls
  initial begin
    int wait_n;
    pose_t e;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_poses.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        e = pending_poses.pop_front();
        if (out_ch.pos_x !== e.px || out_ch.pos_y !== e.py || out_ch.heading !== e.hd ||
            out_ch.linear_speed !== e.spd || out_ch.turn_rate !== e.rate ||
            out_ch.saturated !== e.sat) begin
          $display("%0t: mismatch expected x=%0d y=%0d h=%0d v=%0d w=%0d s=%0b", $time,
                   e.px, e.py, e.hd, e.spd, e.rate, e.sat);
          $display("%0t:          actual x=%0d y=%0d h=%0d v=%0d w=%0d s=%0b", $time,
                   out_ch.pos_x, out_ch.pos_y, out_ch.heading, out_ch.linear_speed,
                   out_ch.turn_rate, out_ch.saturated);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    pose_t p;
    int n;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_STEP;
    in_ch.left_speed = 0;
    in_ch.right_speed = 0;
    in_ch.step_time = 0;
    in_ch.set_x = 0;
    in_ch.set_y = 0;
    in_ch.set_heading = 0;
    cfg.valid = 1'b0;
    cfg.index = REG_LEFT_GAIN;
    cfg.data = 0;
    gain_l = GAIN_RESET;
    gain_r = GAIN_RESET;
    base_w = BASE_RESET;
    pose_x = 0;
    pose_y = 0;
    pose_h = 0;
    last_v = 0;
    last_w = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed table
    p = '{0, 0, 0, 0, 0, 1'b0};
    rows.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0), 1'b1, p});
    p = '{MAX32, MIN32, MAX32, 0, 0, 1'b0};
    rows.push_back('{mk(CMD_SET_POSE, 0, 0, 0, MAX32, MIN32, MAX32), 1'b1, p});
    p = '{MIN32, MAX32, MIN32, 0, 0, 1'b0};
    rows.push_back('{mk(CMD_SET_POSE, -1, -1, 24'hFFFFFF, MIN32, MAX32, MIN32), 1'b1, p});
    p = '{0, 0, 0, 0, 0, 1'b0};
    rows.push_back('{mk(CMD_SET_POSE, 0, 0, 0, 0, 0, 0), 1'b1, p});
    rows.push_back('{mk(CMD_STEP, 32'sh10000, 32'sh10000, 24'h100000, 0, 0, 0), 1'b0, p});
    rows.push_back('{mk(CMD_STEP, 32'sh10000, 32'sh20000, 24'h100000, 0, 0, 0), 1'b0, p});
    rows.push_back('{mk(CMD_STEP, MAX32, MAX32, 24'hFFFFFF, 0, 0, 0), 1'b0, p});
    rows.push_back('{mk(CMD_STEP, MIN32, MAX32, 24'hFFFFFF, 0, 0, 0), 1'b0, p});
    rows.push_back('{mk(CMD_STEP, MAX32, MIN32, 24'hFFFFFF, 0, 0, 0), 1'b0, p});
    rows.push_back('{mk(CMD_STEP, MIN32, MIN32, 24'h000001, 0, 0, 0), 1'b0, p});
    rows.push_back('{mk(CMD_SET_POSE, 0, 0, 0, 0, 0, 32'sh7F000000), 1'b0, p});
    rows.push_back('{mk(CMD_STEP, 32'sh30000, -32'sh30000, 24'h080000, 0, 0, 0), 1'b0, p});
    rows.push_back('{mk(CMD_SET_POSE, 0, 0, 0, 5, 5, 32'sh81000000), 1'b0, p});
    rows.push_back('{mk(CMD_STEP, 32'sh8000, 32'sh9000, 24'h040000, 0, 0, 0), 1'b0, p});
    rows.push_back('{mk(CMD_SET_POSE, 0, 0, 0, 32'sh7FFF0000, 0, 32'sh0), 1'b0, p});
    rows.push_back('{mk(CMD_STEP, 32'sh7FFF0000, 32'sh7FFF0000, 24'hFFFFFF, 0, 0, 0),
                     1'b0, p});
    foreach (rows[i]) begin
      send_item(rows[i].it, 1'b1);
      if (rows[i].known) begin
        pending_poses.pop_back();
        pending_poses.push_back(rows[i].want);
      end
    end
    drain_results();

    // register extremes, including zero base and excess value bits
    write_reg(REG_LEFT_GAIN, 32'hFFFFFFFF);
    write_reg(REG_RIGHT_GAIN, 32'h0);
    write_reg(REG_WHEEL_BASE, 32'h0);
    write_reg(2'd3, 32'h12345);
    for (int i = 0; i < 6; i++) send_item(rnd_item(), 1'b1);
    send_item(mk(CMD_STEP, MAX32, MIN32, 24'hFFFFFF, 0, 0, 0), 1'b0);
    drain_results();
    write_reg(REG_LEFT_GAIN, 32'h0);
    write_reg(REG_RIGHT_GAIN, 32'h3FFFF);
    write_reg(REG_WHEEL_BASE, 32'hFFFFFFFF);
    for (int i = 0; i < 8; i++) send_item(rnd_item(), 1'b1);
    drain_results();

    // random phases with a fresh setting each time
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_LEFT_GAIN, (ph % 3 == 0) ? 32'($urandom) : 32'($urandom_range(50000, 80000)));
      write_reg(REG_RIGHT_GAIN, (ph % 3 == 0) ? 32'($urandom) : 32'($urandom_range(50000, 80000)));
      write_reg(REG_WHEEL_BASE, (ph % 4 == 0) ? 32'($urandom)
                : 32'($urandom_range(1, 200000)));
      if (ph == 5) hold_off = 2000;
      n = 55;
      for (int i = 0; i < n; i++) send_item(rnd_item(), (ph != 5));
      drain_results();
    end
    drain_results();
    repeat (600) @(negedge clk);
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: diff_drive_odometry_core.f
sv/ddo_pkg.sv
sv/ddo_if.sv
sv/ddo_mul.sv
sv/ddo_div.sv
sv/ddo_cordic.sv
sv/diff_drive_odometry_core.sv
sim/testbench.sv
